FILE: design/mme_pkg.sv
`timescale 1ns / 1ps

package mme_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OUT_CNT_W   = 7;

    localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] Q_MAX    = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_MEDIAN = 2'd2,
        CMD_MAD    = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_DRAIN,
        S_DECIDE,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic rd;
        logic decide;
        logic out_load;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic addr_end;
        logic pipe_busy;
        logic last_bit;
        logic need_second;
    } t_sts;

endpackage

FILE: design/mme_ctrl.sv
`timescale 1ns / 1ps

module mme_ctrl
    import mme_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic [1:0] i_cmd,
    input  logic      i_out_stall,
    input  t_sts      i_sts,
    output t_ctl      o_ctl,
    output logic      o_in_stall,
    output logic      o_out_valid
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ctl     = '0;
        n_out_vld = r_out_vld && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_cmd_code'(i_cmd))
                        CMD_CLEAR:  o_ctl.clear  = 1'b1;
                        CMD_APPEND: o_ctl.append = 1'b1;
                        CMD_MEDIAN, CMD_MAD: begin
                            o_ctl.start = 1'b1;
                            n_state     = i_sts.empty ? S_OUT : S_PASS;
                        end
                        default: ;
                    endcase
                end
            end
            S_PASS: begin
                if (i_sts.addr_end) begin
                    n_state = S_DRAIN;
                end else begin
                    o_ctl.rd = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_ctl.decide = 1'b1;
                n_state = (i_sts.last_bit && !i_sts.need_second) ? S_OUT : S_PASS;
            end
            S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    o_ctl.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

FILE: design/mme_dpath.sv
`timescale 1ns / 1ps

module mme_dpath
    import mme_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic [1:0]            i_cmd,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic signed [DATA_W-1:0] i_center,
    output t_sts                  o_sts,
    output logic signed [DATA_W-1:0] o_result,
    output logic                  o_result_kind,
    output logic [OUT_CNT_W-1:0]  o_sample_count,
    output logic                  o_dropped
);

    logic [DATA_W-1:0] r_mem [CAPACITY];

    logic [CNT_W-1:0]  r_held;
    logic              r_drop;
    logic [CNT_W-1:0]  r_n;
    logic              r_kind;
    logic signed [DATA_W-1:0] r_center;
    logic              r_second;

    logic [CNT_W-1:0]  r_addr;
    logic              r_rvld;
    logic signed [DATA_W-1:0] r_rdata;
    logic              r_kvld;
    logic [DATA_W-1:0] r_key;
    logic [CNT_W-1:0]  r_c0;

    logic [DATA_W-1:0] r_prefix, r_mask, r_cur, r_lo;
    logic [CNT_W-1:0]  r_k;

    logic [DATA_W-1:0] r_out_res;
    logic              r_out_kind;
    logic [OUT_CNT_W-1:0] r_out_cnt;
    logic              r_out_drop;

    logic signed [DATA_W:0] dev;
    logic [DATA_W:0]        dev_abs;
    logic [DATA_W-1:0]      n_key;
    logic                   match;
    logic                   k_lt;
    logic [DATA_W-1:0]      n_prefix;
    logic [CNT_W-1:0]       n_k;
    logic [DATA_W:0]        pair_sum;
    logic [DATA_W-1:0]      n_result;
    logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
    logic                   n_even;

    // sort key: sample or saturated deviation, sign flipped for unsigned order
    always_comb begin
        dev     = {r_rdata[DATA_W-1], r_rdata} - {r_center[DATA_W-1], r_center};
        dev_abs = dev[DATA_W] ? (DATA_W+1)'(-dev) : dev;
        if (!r_kind) begin
            n_key = r_rdata ^ SIGN_BIT;
        end else if (dev_abs > {1'b0, Q_MAX}) begin
            n_key = Q_MAX ^ SIGN_BIT;
        end else begin
            n_key = dev_abs[DATA_W-1:0] ^ SIGN_BIT;
        end
    end

    assign match    = ((r_key ^ r_prefix) & (r_mask | r_cur)) == '0;
    assign k_lt     = r_k < r_c0;
    assign n_prefix = k_lt ? r_prefix : (r_prefix | r_cur);
    assign n_k      = k_lt ? r_k : (r_k - r_c0);
    assign n_even   = ~r_held[0];

    assign pair_sum = {1'b0, r_lo} + {1'b0, r_prefix};
    always_comb begin
        if (r_n == '0) begin
            n_result = '0;
        end else if (r_n[0]) begin
            n_result = r_lo ^ SIGN_BIT;
        end else begin
            n_result = pair_sum[DATA_W:1] ^ SIGN_BIT;
        end
    end
    assign cnt_ext = {{OUT_CNT_W{1'b0}}, r_n};

    // sample store
    always_ff @(posedge i_clk) begin
        if (i_ctl.append && (r_held < CNT_W'(CAPACITY))) begin
            r_mem[r_held[ADDR_W-1:0]] <= i_sample;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[r_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_drop   <= 1'b0;
            r_rvld   <= 1'b0;
            r_kvld   <= 1'b0;
            r_n      <= '0;
            r_c0     <= '0;
            r_k      <= '0;
            r_second <= 1'b0;
        end else begin
            r_rvld <= i_ctl.rd;
            r_kvld <= r_rvld;
            if (i_ctl.clear) begin
                r_held <= '0;
                r_drop <= 1'b0;
            end else if (i_ctl.append) begin
                if (r_held < CNT_W'(CAPACITY)) begin
                    r_held <= r_held + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_ctl.start) begin
                r_n      <= r_held;
                r_second <= 1'b0;
                r_c0     <= '0;
                r_k      <= n_even ? (r_held >> 1) - 1'b1 : (r_held >> 1);
            end else if (i_ctl.decide) begin
                r_c0 <= '0;
                if (r_cur[0] && !r_second && !r_n[0]) begin
                    r_second <= 1'b1;
                    r_k      <= r_n >> 1;
                end else begin
                    r_k <= n_k;
                end
            end else if (r_kvld && match) begin
                r_c0 <= r_c0 + 1'b1;
            end
        end
    end

    // select state, payload only
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctl.start) begin
            r_center <= i_center;
            r_kind   <= (t_cmd_code'(i_cmd) == CMD_MAD);
            r_addr   <= '0;
            r_prefix <= '0;
            r_mask   <= '0;
            r_cur    <= SIGN_BIT;
        end else if (i_ctl.decide) begin
            r_addr <= '0;
            if (r_cur[0] && !r_second) begin
                r_lo <= n_prefix;
            end
            if (r_cur[0] && !r_second && !r_n[0]) begin
                r_prefix <= '0;
                r_mask   <= '0;
                r_cur    <= SIGN_BIT;
            end else begin
                r_prefix <= n_prefix;
                r_mask   <= r_mask | r_cur;
                r_cur    <= r_cur >> 1;
            end
        end else if (i_ctl.rd) begin
            r_addr <= r_addr + 1'b1;
        end
        if (i_ctl.out_load) begin
            r_out_res  <= n_result;
            r_out_kind <= r_kind;
            r_out_cnt  <= cnt_ext[OUT_CNT_W-1:0];
            r_out_drop <= r_drop;
        end
    end

    always_comb begin
        o_sts.empty       = (r_held == '0);
        o_sts.addr_end    = (r_addr == r_n);
        o_sts.pipe_busy   = r_rvld | r_kvld;
        o_sts.last_bit    = r_cur[0];
        o_sts.need_second = !r_second && !r_n[0];
    end

    assign o_result       = r_out_res;
    assign o_result_kind  = r_out_kind;
    assign o_sample_count = r_out_cnt;
    assign o_dropped      = r_out_drop;

`ifndef ASSERT_OFF
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c0 <= r_n)
        else $error("rank count exceeds sample count");

    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.decide |-> (r_k < r_n))
        else $error("selected rank out of range");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.append && (r_held < CNT_W'(CAPACITY))) |=> (r_held == $past(r_held) + 1'b1))
        else $error("append did not grow the set");
`endif

endmodule

FILE: design/median_and_mad_engine_top.sv
`timescale 1ns / 1ps

// median and median absolute deviation engine
// input channel: i_in_valid / o_in_stall carry one command item (i_cmd,
//   i_sample, i_center); clear and append give no result
// output channel: o_out_valid / i_out_stall carry one result item per median
//   (cmd 2) or deviation (cmd 3) query, held in an output register
// a query runs a bitwise rank select over the stored samples: each of the 32
//   bit decisions is one read pass over the n held samples followed by pipeline
//   drain and a decision step; an even count runs a second select for the
//   other middle rank (two middle ranks); an empty set skips the passes and
//   answers zero; the single read port of the sample store sets the pass
//   length
// o_in_stall is high while a query is in progress; a new command is taken
//   while an earlier result still waits in the output register
// when the receiver stalls, a finished query waits until the output register
//   frees up and the input stays stalled meanwhile
// reset empties the set, clears the drop flag and the output valid; the
//   sample store itself is not cleared

module median_and_mad_engine_top
    import mme_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_cmd,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic signed [DATA_W-1:0] i_center,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_result,
    output logic                     o_result_kind,
    output logic [OUT_CNT_W-1:0]     o_sample_count,
    output logic                     o_dropped
);

    t_ctl ctl;
    t_sts sts;

    // sequencer: command decode, pass and decision steps, result hand-off
    mme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_ctl       (ctl),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // sample store, key pipeline, rank counter and result register
    mme_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cmd          (i_cmd),
        .i_sample       (i_sample),
        .i_center       (i_center),
        .o_sts          (sts),
        .o_result       (o_result),
        .o_result_kind  (o_result_kind),
        .o_sample_count (o_sample_count),
        .o_dropped      (o_dropped)
    );

endmodule
